FILE: rtl/assert_macros.svh
// Assertion macros shared by the transceiver top level and the receive ring.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_CLK(lbl, !(cond), msg)

`endif

FILE: rtl/uart_pkg.sv
// Types and constants shared by the UART transceiver modules.
package uart_pkg;

	localparam int unsigned RING_DEPTH = 64;
	localparam int unsigned RING_AW = $clog2(RING_DEPTH);

	localparam logic [15:0] BIT_PERIOD_RESET = 16'd434;
	localparam logic [15:0] BIT_PERIOD_MIN = 16'd2;

	// Start bit, eight data bits and the stop bit.
	localparam logic [3:0] TX_FRAME_BITS = 4'd10;
	localparam logic [3:0] RX_DATA_BITS = 4'd8;

	// Register index decoded from paddr[2].
	localparam logic REG_BIT_PERIOD = 1'b0;

	typedef struct packed {
		logic       rx_level;
		logic       send;
		logic [7:0] send_byte;
		logic [5:0] read_slot;
	} item_t;

	typedef struct packed {
		logic       tx_level;
		logic       tx_idle;
		logic       byte_stored;
		logic [7:0] received_byte;
		logic       data_ready;
		logic [5:0] write_slot;
		logic [7:0] slot_data;
	} result_t;

	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
		logic [7:0]         data;
	} ring_wr_t;

endpackage

FILE: rtl/uart_8n1_transceiver.sv
// UART 8N1 transceiver top level: APB register, item handshake and result register.
//
// Every accepted item is one baud-timer tick and gives exactly one result,
// presented on the cycle after the transfer; a new item is taken every clock
// cycle as long as the result side keeps up. The ring memory's read and write
// both happen on the accepting edge, with the read data registered. The ring's
// 64 entries carry reset-cleared valid bits, so the block takes items straight
// out of reset. bit_period sits at APB address 0 (reset 434, values below 2
// act as 2) and should only be written while no result is outstanding.
module uart_8n1_transceiver (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             item_valid,
	output logic             item_ready,
	input  uart_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_ready,
	output uart_pkg::result_t result
);
	import uart_pkg::*;
	`include "assert_macros.svh"

	logic               step;
	logic [15:0]        bit_period_q;
	logic [15:0]        period;
	logic               result_valid_q;
	ring_wr_t           ring_wr;
	logic [RING_AW-1:0] write_slot;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= BIT_PERIOD_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_BIT_PERIOD)) begin
			bit_period_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == REG_BIT_PERIOD) ? {16'd0, bit_period_q} : 32'd0;
	assign period = (bit_period_q < BIT_PERIOD_MIN) ? BIT_PERIOD_MIN : bit_period_q;

	// Block state only moves on a transfer, so the result fields hold while
	// the result waits.
	assign item_ready = !result_valid_q || result_ready;
	assign step = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

	uart_tx u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.send      (item.send),
		.send_byte (item.send_byte),
		.period    (period),
		.tx_level  (result.tx_level),
		.tx_idle   (result.tx_idle)
	);

	uart_rx u_rx (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.rx_level      (item.rx_level),
		.period        (period),
		.wr            (ring_wr),
		.byte_stored   (result.byte_stored),
		.received_byte (result.received_byte),
		.data_ready    (result.data_ready),
		.write_slot    (write_slot)
	);

	assign result.write_slot = 6'(write_slot);

	uart_ring u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.wr        (ring_wr),
		.read_slot (item.read_slot[RING_AW-1:0]),
		.slot_data (result.slot_data)
	);

	`ASSERT_CLK(a_stored_sets_ready,
		result_valid && result.byte_stored |-> result.data_ready,
		"byte stored without data_ready")
	`ASSERT_NEVER(a_idle_line_high,
		result.tx_idle && !result.tx_level,
		"transmit line low while transmitter idle")
	`ASSERT_CLK(a_slot_advances,
		step && ring_wr.en |=> write_slot == $past(ring_wr.addr) + 1'b1,
		"ring write index did not advance after a store")

endmodule

FILE: rtl/uart_tx.sv
// Transmit bit timer and frame shifter.
module uart_tx (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        send,
	input  logic [7:0]  send_byte,
	input  logic [15:0] period,
	output logic        tx_level,
	output logic        tx_idle
);
	import uart_pkg::*;

	logic [15:0] cnt_q, cnt_n;
	logic [3:0]  phase_q, phase_n;
	logic [7:0]  shift_q, shift_n;
	logic        line_q, line_n;
	logic [16:0] cnt_inc;
	logic [3:0]  phase_dec;

	assign cnt_inc = {1'b0, cnt_q} + 17'd1;
	assign phase_dec = phase_q - 4'd1;

	always_comb begin
		cnt_n = cnt_q;
		phase_n = phase_q;
		shift_n = shift_q;
		line_n = line_q;
		if (phase_q != 4'd0) begin
			if (cnt_inc >= {1'b0, period}) begin
				cnt_n = 16'd0;
				phase_n = phase_dec;
				if (phase_dec >= 4'd2) begin
					line_n = shift_q[0];
					shift_n = {1'b0, shift_q[7:1]};
				end else if (phase_dec == 4'd1) begin
					line_n = 1'b1;
				end
			end else begin
				cnt_n = cnt_inc[15:0];
			end
		end else if (send) begin
			phase_n = TX_FRAME_BITS;
			cnt_n = 16'd0;
			shift_n = send_byte;
			line_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 16'd0;
			phase_q <= 4'd0;
			shift_q <= 8'd0;
			line_q <= 1'b1;
		end else if (step) begin
			cnt_q <= cnt_n;
			phase_q <= phase_n;
			shift_q <= shift_n;
			line_q <= line_n;
		end
	end

	assign tx_level = line_q;
	assign tx_idle = (phase_q == 4'd0);

endmodule

FILE: rtl/uart_rx.sv
// Receive edge detect, sample timer, shifter and ring write pointer.
module uart_rx (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   rx_level,
	input  logic [15:0]            period,
	output uart_pkg::ring_wr_t     wr,
	output logic                   byte_stored,
	output logic [7:0]             received_byte,
	output logic                   data_ready,
	output logic [uart_pkg::RING_AW-1:0] write_slot
);
	import uart_pkg::*;

	logic               last_q;
	logic               busy_q, busy_n;
	logic [16:0]        cnt_q, cnt_n;
	logic [3:0]         bits_q, bits_n;
	logic [7:0]         shift_q, shift_n;
	logic               ready_q, ready_n;
	logic [RING_AW-1:0] widx_q;
	logic               stored_q;
	logic [7:0]         rbyte_q;
	logic [16:0]        half;
	logic [16:0]        target;
	logic [16:0]        cnt_inc;

	// First sample lands in the middle of bit 0: three halves of a period.
	assign half = {2'b00, period[15:1]};
	assign target = (bits_q == 4'd0) ? (half + {half[15:0], 1'b0}) : {1'b0, period};
	assign cnt_inc = cnt_q + 17'd1;

	always_comb begin
		busy_n = busy_q;
		cnt_n = cnt_q;
		bits_n = bits_q;
		shift_n = shift_q;
		ready_n = ready_q;
		wr.en = 1'b0;
		wr.addr = widx_q;
		wr.data = shift_q;
		if (busy_q) begin
			if (cnt_inc >= target) begin
				cnt_n = 17'd0;
				if (bits_q < RX_DATA_BITS) begin
					shift_n = {rx_level, shift_q[7:1]};
					bits_n = bits_q + 4'd1;
				end else begin
					wr.en = 1'b1;
					ready_n = 1'b1;
					busy_n = 1'b0;
					bits_n = 4'd0;
				end
			end else begin
				cnt_n = cnt_inc;
			end
		end else if (last_q && !rx_level) begin
			busy_n = 1'b1;
			ready_n = 1'b0;
			cnt_n = 17'd0;
			bits_n = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b1;
			busy_q <= 1'b0;
			cnt_q <= 17'd0;
			bits_q <= 4'd0;
			shift_q <= 8'd0;
			ready_q <= 1'b0;
			widx_q <= '0;
			stored_q <= 1'b0;
			rbyte_q <= 8'd0;
		end else if (step) begin
			last_q <= rx_level;
			busy_q <= busy_n;
			cnt_q <= cnt_n;
			bits_q <= bits_n;
			shift_q <= shift_n;
			ready_q <= ready_n;
			stored_q <= wr.en;
			rbyte_q <= wr.en ? shift_q : 8'd0;
			if (wr.en) begin
				widx_q <= widx_q + 1'b1;
			end
		end
	end

	assign byte_stored = stored_q;
	assign received_byte = rbyte_q;
	assign data_ready = ready_q;
	assign write_slot = widx_q;

endmodule

FILE: rtl/uart_ring.sv
// Receive ring: synchronous memory, per-entry valid bits and write forwarding.
module uart_ring (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  uart_pkg::ring_wr_t         wr,
	input  logic [uart_pkg::RING_AW-1:0] read_slot,
	output logic [7:0]                 slot_data
);
	import uart_pkg::*;
	`include "assert_macros.svh"

	logic [7:0]            mem [RING_DEPTH];
	logic [RING_DEPTH-1:0] valid_q;
	logic [7:0]            rdata_q;
	logic                  rvalid_q;
	logic                  hit_q;
	logic [7:0]            fwd_q;

	// The memory returns the old entry, so a write to the slot being read
	// in the same transfer is forwarded around it.
	always_ff @(posedge clk) begin
		if (step) begin
			if (wr.en) begin
				mem[wr.addr] <= wr.data;
			end
			rdata_q <= mem[read_slot];
			fwd_q <= wr.data;
		end
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
			hit_q <= 1'b0;
		end else if (step) begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			rvalid_q <= valid_q[read_slot];
			hit_q <= wr.en && (wr.addr == read_slot);
		end
	end

	assign slot_data = hit_q ? fwd_q : (rvalid_q ? rdata_q : 8'd0);

	`ASSERT_CLK(a_fwd_same_slot,
		step && wr.en && (wr.addr == read_slot) |=> slot_data == $past(wr.data),
		"write to the slot being read was not forwarded")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the 8N1 UART transceiver: per-tick predictor, handshake driver and monitor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import uart_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam logic [2:0] BIT_PERIOD_ADDR = {REG_BIT_PERIOD, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;

	uart_8n1_transceiver u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	item_t       tick_queue[$];
	result_t     expected_outputs[$];
	int unsigned bad_count = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;

	// Predicted UART state.
	logic [15:0]        bit_period_q;
	logic               line_prev;
	logic               rx_active;
	logic [16:0]        rx_count;
	logic [3:0]         rx_nbits;
	logic [7:0]         rx_sr;
	logic [7:0]         ring_mem [RING_DEPTH];
	logic [RING_AW-1:0] wr_ptr;
	logic               ready_q;
	logic [15:0]        tx_count;
	logic [3:0]         tx_bits_left;
	logic [7:0]         tx_sr;
	logic               tx_pin;

	// Sender burst and gap control.
	int burst_left = 1;
	int gap_left = 0;

	// Receiver stall pattern and the single long hold-off.
	logic [31:0] stall_pattern = '1;
	logic [4:0]  stall_phase = '0;
	int          hold_cycles = 0;
	logic        hold_done = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic result_t advance_uart(input item_t t);
		result_t     r;
		logic [16:0] p;
		logic [16:0] target;
		logic        stored;
		logic [7:0]  got;
		p = (bit_period_q < BIT_PERIOD_MIN) ? 17'(BIT_PERIOD_MIN) : 17'(bit_period_q);
		stored = 1'b0;
		got = '0;

		if (tx_bits_left != 0) begin
			tx_count = tx_count + 16'd1;
			if (17'(tx_count) >= p) begin
				tx_count = '0;
				tx_bits_left = tx_bits_left - 4'd1;
				if (tx_bits_left >= 4'd2) begin
					tx_pin = tx_sr[0];
					tx_sr = tx_sr >> 1;
				end else if (tx_bits_left == 4'd1) begin
					tx_pin = 1'b1;
				end
			end
		end else if (t.send) begin
			tx_bits_left = TX_FRAME_BITS;
			tx_count = '0;
			tx_sr = t.send_byte;
			tx_pin = 1'b0;
		end

		if (rx_active) begin
			// The first data bit is taken one and a half periods after the start edge.
			target = (rx_nbits == 0) ? (p >> 1) * 17'd3 : p;
			rx_count = rx_count + 17'd1;
			if (rx_count >= target) begin
				rx_count = '0;
				if (rx_nbits < RX_DATA_BITS) begin
					rx_sr = {t.rx_level, rx_sr[7:1]};
					rx_nbits = rx_nbits + 4'd1;
				end else begin
					ring_mem[wr_ptr] = rx_sr;
					wr_ptr = wr_ptr + 1'b1;
					got = rx_sr;
					stored = 1'b1;
					ready_q = 1'b1;
					rx_active = 1'b0;
					rx_nbits = '0;
				end
			end
		end else if (line_prev && !t.rx_level) begin
			rx_active = 1'b1;
			ready_q = 1'b0;
			rx_count = '0;
			rx_nbits = '0;
		end
		line_prev = t.rx_level;

		r.tx_level = tx_pin;
		r.tx_idle = (tx_bits_left == 0);
		r.byte_stored = stored;
		r.received_byte = got;
		r.data_ready = ready_q;
		r.write_slot = wr_ptr;
		r.slot_data = ring_mem[t.read_slot];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			bad_count++;
			if (bad_count <= 10)
				$display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
		end
	endtask

	task automatic check_outputs(input result_t want, input result_t got);
		check_field("tx_level", 32'(want.tx_level), 32'(got.tx_level));
		check_field("tx_idle", 32'(want.tx_idle), 32'(got.tx_idle));
		check_field("byte_stored", 32'(want.byte_stored), 32'(got.byte_stored));
		check_field("received_byte", 32'(want.received_byte), 32'(got.received_byte));
		check_field("data_ready", 32'(want.data_ready), 32'(got.data_ready));
		check_field("write_slot", 32'(want.write_slot), 32'(got.write_slot));
		check_field("slot_data", 32'(want.slot_data), 32'(got.slot_data));
	endtask

	task automatic add_tick(input logic rx, input logic snd, input logic [7:0] data,
			input logic [5:0] slot);
		item_t t;
		t.rx_level = rx;
		t.send = snd;
		t.send_byte = data;
		t.read_slot = slot;
		tick_queue.push_back(t);
	endtask

	// Holds the receive line at one level for n ticks with random transmit and read fields.
	task automatic push_level(input logic level, input int n);
		for (int i = 0; i < n; i++)
			add_tick(level, $urandom_range(0, 3) == 0, 8'($urandom), 6'($urandom));
	endtask

	task automatic queue_random_ticks(input int n);
		int         p;
		int         start;
		int         kind;
		logic [7:0] data;
		p = int'((bit_period_q < BIT_PERIOD_MIN) ? BIT_PERIOD_MIN : bit_period_q);
		start = tick_queue.size();
		while (tick_queue.size() - start < n) begin
			kind = (p > 16) ? 7 : $urandom_range(0, 9);
			if (kind <= 6) begin
				// Well-formed frame; at a period of 2 a stop bit one tick short lets the next
				// start edge land on the tick the previous byte is stored.
				data = 8'($urandom);
				push_level(1'b0, p);
				for (int b = 0; b < 8; b++)
					push_level(data[b], p);
				push_level(1'b1, $urandom_range(p - 1, p + 3));
			end else if (kind == 7) begin
				// At long periods each noise burst is capped at the requested tick count.
				repeat ($urandom_range(1, (3 * p < n) ? 3 * p : n))
					push_level(1'($urandom_range(0, 1)), 1);
			end else if (kind == 8) begin
				push_level(1'b0, $urandom_range(1, p));
				push_level(1'b1, $urandom_range(1, p));
			end else begin
				push_level(1'b1, $urandom_range(1, 2 * p));
			end
		end
	endtask

	task automatic wait_drained();
		while (tick_queue.size() != 0 || item_valid || expected_outputs.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_bit_period(input logic [15:0] value);
		wait_drained();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BIT_PERIOD_ADDR;
		pwdata <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// Straight into a read of the same register to confirm the write.
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== value) begin
			bad_count++;
			if (bad_count <= 10)
				$display("bit_period read back %0h, expected %0h", prdata[15:0], value);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		bit_period_q = value;
		@(negedge clk);
	endtask

	// Sender: bursts of transfers separated by random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				item_valid <= 1'b0;
			end else if (tick_queue.size() != 0) begin
				item <= tick_queue.pop_front();
				item_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: a rotating stall pattern, reloaded each time the 5-bit phase wraps, and one long hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
			result_ready <= 1'b0;
		end else if (!hold_done && results_seen >= 250) begin
			hold_done <= 1'b1;
			hold_cycles <= 300;
			result_ready <= 1'b0;
		end else begin
			stall_phase <= stall_phase + 5'd1;
			if (stall_phase == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pattern <= '1;
					1: stall_pattern <= $urandom;
					default: stall_pattern <= $urandom | $urandom;
				endcase
			end
			result_ready <= stall_pattern[stall_phase];
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				expected_outputs.push_back(advance_uart(item));
			if (result_valid && result_ready) begin
				results_seen <= results_seen + 1;
				if (expected_outputs.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("result %0d arrived with no transfer waiting for it", results_seen);
				end else begin
					check_outputs(expected_outputs.pop_front(), result);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		bit_period_q = BIT_PERIOD_RESET;
		line_prev = 1'b1;
		rx_active = 1'b0;
		rx_count = '0;
		rx_nbits = '0;
		rx_sr = '0;
		for (int i = 0; i < RING_DEPTH; i++)
			ring_mem[i] = '0;
		wr_ptr = '0;
		ready_q = 1'b0;
		tx_count = '0;
		tx_bits_left = '0;
		tx_sr = '0;
		tx_pin = 1'b1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed ticks at the reset period: transmit of all ones, a send while busy,
		// a start edge, an edge while receiving and the outermost read slots.
		add_tick(1'b1, 1'b0, 8'h00, 6'd0);
		add_tick(1'b1, 1'b1, 8'hFF, 6'd63);
		add_tick(1'b1, 1'b1, 8'h00, 6'd0);
		add_tick(1'b0, 1'b0, 8'h5A, 6'h2A);
		add_tick(1'b1, 1'b0, 8'h00, 6'h15);
		add_tick(1'b0, 1'b1, 8'hA5, 6'd1);
		add_tick(1'b1, 1'b0, 8'h00, 6'd62);
		add_tick(1'b1, 1'b1, 8'h80, 6'd63);

		// A new period can land while frames from the previous one are still running.
		write_bit_period(16'd2);
		queue_random_ticks(200);
		write_bit_period(16'd0);
		queue_random_ticks(200);
		write_bit_period(16'd3);
		queue_random_ticks(60);
		write_bit_period(16'hFFFF);
		queue_random_ticks(24);
		write_bit_period(16'd1);
		queue_random_ticks(200);
		write_bit_period(16'd5);
		queue_random_ticks(60);
		write_bit_period(16'd2);
		queue_random_ticks(150);

		wait_drained();
		repeat (8) @(posedge clk);
		if (bad_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
